// ===== hw/rtl/esf_pkg.sv =====
// Shared types and constants for the Ethernet payload string filter.
// No dependencies; imported by every module of the block.
`default_nettype none

package esf_pkg;

  typedef logic [7:0] byte_t;

  // Control from the header parser to the payload window.
  typedef struct packed {
    logic take;   // shift the current byte into the window
    logic clear;  // frame ends: drop fill count and match flag
  } win_ctl_t;

  localparam int unsigned ETH_HDR   = 14;
  localparam int unsigned MIN_HDR   = 20;
  localparam int unsigned SMALL_HDR = 8;

  localparam logic [15:0] TYPE_IPV4 = 16'h0800;
  localparam logic [15:0] TYPE_ARP  = 16'h0806;

  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_TCP  = 8'd6;
  localparam logic [7:0] PROTO_UDP  = 8'd17;
  localparam logic [7:0] PROTO_ZERO = 8'd0;

  localparam logic [3:0] CLS_TCP      = 4'd0;
  localparam logic [3:0] CLS_UDP      = 4'd1;
  localparam logic [3:0] CLS_ICMP     = 4'd2;
  localparam logic [3:0] CLS_IP_ZERO  = 4'd3;
  localparam logic [3:0] CLS_IP_OTHER = 4'd4;
  localparam logic [3:0] CLS_ARP      = 4'd5;
  localparam logic [3:0] CLS_OTHER    = 4'd6;
  localparam logic [3:0] CLS_BAD_IP   = 4'd7;
  localparam logic [3:0] CLS_BAD_TCP  = 4'd8;
  localparam logic [3:0] CLS_SHORT    = 4'd9;

  localparam logic [1:0] CFG_PAT_LEN  = 2'd0;
  localparam logic [1:0] CFG_PAT_LOW  = 2'd1;
  localparam logic [1:0] CFG_PAT_HIGH = 2'd2;

endpackage

`default_nettype wire

// ===== hw/rtl/esf_cell.sv =====
// One cell of the payload window: holds one byte and compares the byte it takes in.
// Depends on esf_pkg.
`default_nettype none

module esf_cell (
  input  wire logic          clk,
  input  wire logic          shift_en,
  input  wire esf_pkg::byte_t d_in,
  input  wire esf_pkg::byte_t pat,
  input  wire logic          care,
  output esf_pkg::byte_t     q,
  output logic               eq
);
  import esf_pkg::*;

  byte_t q_r;

  // compare on the byte entering the cell, i.e. the window after this shift
  assign eq = !care || (d_in == pat);
  assign q  = q_r;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      q_r <= d_in;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/esf_window.sv =====
// Payload window: a chain of byte cells with fill count and sticky match flag.
// Depends on esf_pkg and esf_cell.
`default_nettype none

module esf_window #(
  parameter int PAT_BYTES = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire esf_pkg::win_ctl_t ctl,
  input  wire esf_pkg::byte_t    in_byte,
  input  wire logic [4:0]        pat_len,
  input  wire logic [63:0]       pat_low,
  input  wire logic [63:0]       pat_high,
  output logic                   match_now
);
  import esf_pkg::*;

  localparam int FW = $clog2(PAT_BYTES + 1);

  logic [4:0]        n_used;
  logic [FW-1:0]     fill_r, fill_nxt;
  logic              match_r;
  logic              hit;
  byte_t             q   [PAT_BYTES];
  byte_t             din [PAT_BYTES];
  byte_t             pat [PAT_BYTES];
  logic [PAT_BYTES-1:0] eq, care;

  assign n_used = (pat_len > 5'(PAT_BYTES)) ? 5'(PAT_BYTES) : pat_len;

  // cell PAT_BYTES-1 takes the newest byte; each cell hands its byte down
  for (genvar j = 0; j < PAT_BYTES; j++) begin : g_cell
    logic [5:0] k;
    assign k       = 6'(j) + 6'(n_used) - 6'(PAT_BYTES);
    assign care[j] = (6'(j) + 6'(n_used)) >= 6'(PAT_BYTES);
    assign pat[j]  = k[3] ? pat_high[8*k[2:0] +: 8] : pat_low[8*k[2:0] +: 8];
    if (j == PAT_BYTES - 1) begin : g_top
      assign din[j] = in_byte;
    end else begin : g_mid
      assign din[j] = q[j+1];
    end
    esf_cell u_cell (
      .clk      (clk),
      .shift_en (ctl.take),
      .d_in     (din[j]),
      .pat      (pat[j]),
      .care     (care[j]),
      .q        (q[j]),
      .eq       (eq[j])
    );
  end

  always_comb begin
    fill_nxt = fill_r;
    if (ctl.take && (fill_r != FW'(PAT_BYTES))) begin
      fill_nxt = fill_r + FW'(1);
    end
  end

  assign hit       = ctl.take && (n_used != 5'd0) && (5'(fill_nxt) >= n_used) && (&eq);
  assign match_now = match_r | hit;

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      fill_r  <= '0;
      match_r <= 1'b0;
    end else begin
      fill_r  <= fill_nxt;
      match_r <= match_now;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/ethernet_payload_string_filter.sv =====
// The result of a frame passes through the snapshot stage and then the output register.
// Throughput: one byte per cycle while in_tready is high; the window compare over the
// cell chain finishes in the cycle the byte shifts in, and header fields are captured as they pass.
// One snapshot stage and one output register hold up to two frame results.
// Reset (rst_n low, synchronous) clears the pattern registers, frame state and valids.
`default_nettype none

module ethernet_payload_string_filter #(
  parameter int FRAME_BYTES   = 2048,
  parameter int PAT_BYTES     = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // frame bytes
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] frame_byte
  input  wire logic        in_tlast,   // frame_end
  // one result per frame
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // [0] report, [4:1] frame_class, [5] pattern_found,
                                       // [17:6] payload_offset, [33:18] payload_length
  // configuration
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_wdata
);
  import esf_pkg::*;

  localparam int IW = $clog2(FRAME_BYTES + 1);

  // configuration
  logic [4:0]  pat_len_r;
  logic [63:0] pat_low_r, pat_high_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_len_r  <= '0;
      pat_low_r  <= '0;
      pat_high_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PAT_LEN:  pat_len_r  <= cfg_wdata[4:0];
        CFG_PAT_LOW:  pat_low_r  <= cfg_wdata;
        CFG_PAT_HIGH: pat_high_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // handshake
  logic in_acc, out_load, s_vld_r, out_vld_r, s_load;

  assign in_acc    = in_tvalid && in_tready;
  assign out_load  = s_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !s_vld_r || out_load;
  assign s_load    = in_acc && in_tlast;

  // header parser
  logic [IW-1:0] idx_r, idx_nxt;
  logic [15:0]   ether_r, ether_nxt;
  logic [6:0]    ihl_r, ihl_nxt;
  logic [7:0]    proto_r, proto_nxt;
  logic [15:0]   total_r, total_nxt;
  logic [6:0]    thl_r, thl_nxt;
  logic          live;
  logic          hdr_ok, pay_ok;
  logic [7:0]    hdr;
  logic [16:0]   idx_w;
  win_ctl_t      wctl;
  logic          match_now;

  assign live  = idx_r < IW'(FRAME_BYTES);
  assign idx_w = 17'(idx_r);

  always_comb begin
    idx_nxt   = idx_r;
    ether_nxt = ether_r;
    ihl_nxt   = ihl_r;
    proto_nxt = proto_r;
    total_nxt = total_r;
    thl_nxt   = thl_r;
    if (in_acc && live) begin
      idx_nxt = idx_r + IW'(1);
      priority if (idx_r == IW'(12)) ether_nxt = {in_tdata, 8'h00};
      else if (idx_r == IW'(13))     ether_nxt = {ether_r[15:8], in_tdata};
      else if (idx_r == IW'(14))     ihl_nxt   = {1'b0, in_tdata[3:0], 2'b00};
      else if (idx_r == IW'(16))     total_nxt = {in_tdata, 8'h00};
      else if (idx_r == IW'(17))     total_nxt = {total_r[15:8], in_tdata};
      else if (idx_r == IW'(23))     proto_nxt = in_tdata;
      else ;
      // data offset byte of the transport header
      if ((ihl_r >= 7'(MIN_HDR)) && (idx_r == IW'(ETH_HDR + 12) + IW'(ihl_r))) begin
        thl_nxt = {1'b0, in_tdata[7:4], 2'b00};
      end
    end
  end

  // payload span test; fields read here never change on a byte inside the span
  always_comb begin
    hdr_ok = 1'b0;
    hdr    = 8'(ihl_r) + 8'(SMALL_HDR);
    pay_ok = 1'b0;
    priority if (idx_r < IW'(ETH_HDR)) begin
      pay_ok = 1'b0;
    end else if (ether_r != TYPE_IPV4) begin
      pay_ok = 1'b1;
    end else if ((ihl_r < 7'(MIN_HDR)) || (idx_r < IW'(24))) begin
      pay_ok = 1'b0;
    end else begin
      priority if (proto_r == PROTO_TCP) begin
        hdr_ok = thl_r >= 7'(MIN_HDR);
        hdr    = 8'(ihl_r) + 8'(thl_r);
      end else if ((proto_r == PROTO_UDP) || (proto_r == PROTO_ICMP)) begin
        hdr_ok = 1'b1;
      end else begin
        hdr_ok = 1'b0;
      end
      pay_ok = hdr_ok && (total_r > 16'(hdr))
            && (idx_w >= 17'(ETH_HDR) + 17'(hdr))
            && (idx_w < 17'(total_r) + 17'(ETH_HDR));
    end
  end

  assign wctl.take  = in_acc && live && pay_ok;
  assign wctl.clear = s_load;

  always_ff @(posedge clk) begin
    if (!rst_n || s_load) begin
      idx_r   <= '0;
      ether_r <= '0;
      ihl_r   <= '0;
      proto_r <= '0;
      total_r <= '0;
      thl_r   <= '0;
    end else begin
      idx_r   <= idx_nxt;
      ether_r <= ether_nxt;
      ihl_r   <= ihl_nxt;
      proto_r <= proto_nxt;
      total_r <= total_nxt;
      thl_r   <= thl_nxt;
    end
  end

  esf_window #(
    .PAT_BYTES (PAT_BYTES)
  ) u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (wctl),
    .in_byte   (in_tdata),
    .pat_len   (pat_len_r),
    .pat_low   (pat_low_r),
    .pat_high  (pat_high_r),
    .match_now (match_now)
  );

  // snapshot of the finished frame
  logic [IW-1:0] s_flen_r;
  logic [15:0]   s_ether_r, s_total_r;
  logic [6:0]    s_ihl_r, s_thl_r;
  logic [7:0]    s_proto_r;
  logic          s_match_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_vld_r <= 1'b0;
    end else begin
      s_vld_r <= s_load || (s_vld_r && !out_load);
    end
  end

  always_ff @(posedge clk) begin
    if (s_load) begin
      s_flen_r  <= idx_nxt;
      s_ether_r <= ether_nxt;
      s_ihl_r   <= ihl_nxt;
      s_proto_r <= proto_nxt;
      s_total_r <= total_nxt;
      s_thl_r   <= thl_nxt;
      s_match_r <= match_now;
    end
  end

  // classify
  logic [3:0]  cls;
  logic [7:0]  s_hdr;
  logic [11:0] off;
  logic [15:0] plen;
  logic [16:0] flen_w, ihl_w;
  logic        filt, rep, found;

  assign flen_w = 17'(s_flen_r);
  assign ihl_w  = 17'(s_ihl_r);

  always_comb begin
    cls   = CLS_OTHER;
    s_hdr = 8'(s_ihl_r) + 8'(SMALL_HDR);
    off   = '0;
    plen  = '0;
    priority if (flen_w < 17'(ETH_HDR)) begin
      cls = CLS_SHORT;
    end else if (s_ether_r == TYPE_IPV4) begin
      priority if (flen_w < 17'(ETH_HDR + 1)) cls = CLS_SHORT;
      else if (s_ihl_r < 7'(MIN_HDR))         cls = CLS_BAD_IP;
      else if (flen_w < 17'(ETH_HDR) + ihl_w) cls = CLS_SHORT;
      else if (s_proto_r == PROTO_TCP) begin
        priority if (flen_w < 17'(ETH_HDR + 13) + ihl_w) cls = CLS_SHORT;
        else if (s_thl_r < 7'(MIN_HDR))                  cls = CLS_BAD_TCP;
        else begin
          cls   = CLS_TCP;
          s_hdr = 8'(s_ihl_r) + 8'(s_thl_r);
        end
      end
      else if (s_proto_r == PROTO_UDP)  cls = CLS_UDP;
      else if (s_proto_r == PROTO_ICMP) cls = CLS_ICMP;
      else if (s_proto_r == PROTO_ZERO) cls = CLS_IP_ZERO;
      else                              cls = CLS_IP_OTHER;
      if (cls <= CLS_ICMP) begin
        off  = 12'(ETH_HDR) + 12'(s_hdr);
        plen = (s_total_r > 16'(s_hdr)) ? (s_total_r - 16'(s_hdr)) : 16'd0;
      end
    end else begin
      cls  = (s_ether_r == TYPE_ARP) ? CLS_ARP : CLS_OTHER;
      off  = 12'(ETH_HDR);
      plen = 16'(s_flen_r) - 16'(ETH_HDR);
    end
  end

  assign filt  = pat_len_r != 5'd0;
  assign found = filt && s_match_r;
  assign rep   = ((cls <= CLS_ICMP) || (cls == CLS_ARP) || (cls == CLS_OTHER))
              && (!filt || s_match_r);

  // output register
  logic        out_rep_r, out_found_r;
  logic [3:0]  out_cls_r;
  logic [11:0] out_off_r;
  logic [15:0] out_plen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_load) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_rep_r   <= rep;
      out_cls_r   <= cls;
      out_found_r <= found;
      out_off_r   <= off;
      out_plen_r  <= plen;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {6'd0, out_plen_r, out_off_r, out_found_r, out_cls_r, out_rep_r};

`ifndef SYNTHESIS
  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= IW'(FRAME_BYTES))
    else $error("byte index past frame limit");

  a_idx_clear: assert property (@(posedge clk) disable iff (!rst_n)
    s_load |=> (idx_r == '0) && (ether_r == '0))
    else $error("frame state not cleared after last item");

  a_report_cls: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_rep_r |->
      (out_cls_r <= CLS_ICMP) || (out_cls_r == CLS_ARP) || (out_cls_r == CLS_OTHER))
    else $error("report set for a class that is never reported");

  a_unused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && ((out_cls_r == CLS_IP_ZERO) || (out_cls_r == CLS_IP_OTHER)
      || (out_cls_r == CLS_BAD_IP) || (out_cls_r == CLS_BAD_TCP)
      || (out_cls_r == CLS_SHORT)) |-> (out_off_r == '0) && (out_plen_r == '0))
    else $error("offset or length set for a class without payload");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    s_vld_r && out_vld_r && !out_tready |=> $stable(s_flen_r) && s_vld_r)
    else $error("snapshot overwritten while output stalled");
`endif

endmodule

`default_nettype wire
